// ===== src/xxh_pkg.sv =====
// package: xxh64 constants, sequencer states and shared arithmetic helpers
`default_nettype none
package xxh_pkg;
    localparam int unsigned STRIPE_BYTES = 32;
    localparam int unsigned FILL_W = $clog2(STRIPE_BYTES);
    localparam int unsigned WORD_W = 64;

    localparam logic [63:0] P1 = 64'h9e3779b185ebca87;
    localparam logic [63:0] P2 = 64'hc2b2ae3d27d4eb4f;
    localparam logic [63:0] P3 = 64'h165667b19e3779f9;
    localparam logic [63:0] P4 = 64'h85ebca77c2b2ae63;
    localparam logic [63:0] P5 = 64'h27d4eb2f165667c5;

    // multiplier operation selects (shared 64x64 low product unit)
    typedef enum logic [1:0] {
        t_MUL_IDLE,
        t_MUL_START
    } t_mul_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LANE_MUL0,   // acc += word*P2
        S_LANE_MUL1,   // acc = rotl(acc,31)*P1
        S_LANE_NEXT,
        S_FIN_START,
        S_MRG_MUL0,    // v = acc*P2
        S_MRG_MUL1,    // v = rotl(v,31)*P1 ; h ^= v
        S_MRG_MUL2,    // h = h*P1 + P4
        S_ADD_LEN,
        S_T8_MUL0,
        S_T8_MUL1,
        S_T8_MUL2,
        S_T4_MUL0,
        S_T4_MUL1,
        S_T1_MUL0,
        S_T1_MUL1,
        S_AV_MUL0,
        S_AV_MUL1,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
        logic [127:0] d;
        d = {x, x} << n;
        return d[127:64];
    endfunction
endpackage
`default_nettype wire

// ===== src/xxh_mul.sv =====
// shared multi-cycle 64x64 multiplier, low 64 bits, 16-bit b digit per cycle
`default_nettype none
module xxh_mul (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire xxh_pkg::t_mul_req    i_req,
    output logic                      o_done,
    output logic [63:0]               o_prod
);
    import xxh_pkg::*;

    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] w_part;

    // 64x16 partial product, kept to the low 64 bits
    assign w_part = r_a * {48'd0, r_b[15:0]};

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a = i_req.a;
            n_b = i_req.b;
            n_acc = '0;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_acc + w_part;
            n_a = r_a << 16;
            n_b = r_b >> 16;
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd3) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// ===== src/xxh64_stream_hasher.sv =====
// top level: byte-serial xxh64 with one shared iterative multiplier
// a plain byte is accepted in idle; a byte closing a stripe keeps input off while the
//   four lanes are updated (two products each in the shared multiplier, one lane step each)
// a last item keeps the block busy through merge (long messages), tail and avalanche
// throughput: one item at a time, ready only in idle
// reset: synchronous active low; seed 0, lanes reloaded, fill and length zero
`default_nettype none
module xxh64_stream_hasher #(
    parameter int unsigned STRIPE = xxh_pkg::STRIPE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_digest,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata
);
    import xxh_pkg::*;

    localparam int unsigned FW = $clog2(STRIPE);

    t_state      r_state, n_state;
    logic [63:0] r_seed;
    logic [63:0] r_lane [4];
    logic [7:0]  r_buf [STRIPE];
    logic [FW-1:0] r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic [1:0]  r_lidx, n_lidx;   // lane index in stripe update and merge
    logic [FW-1:0] r_pos, n_pos;  // tail read position
    logic [FW:0]   r_left, n_left; // tail bytes left
    logic [63:0] r_h, n_h;
    logic [63:0] r_v, n_v;
    logic        r_last, n_last;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_dig, n_dig;
    logic        r_mwait, n_mwait;  // a product is in flight

    t_mul_req    w_req;
    logic        w_mdone;
    logic [63:0] w_prod;

    logic        w_acc;
    logic [63:0] w_word8, w_word4, w_lane_word;
    logic        w_lane_we;
    logic [63:0] w_lane_wd;

    xxh_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_acc    = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_digest = r_dig;

    // little-endian words from the stripe buffer
    always_comb begin
        w_word8 = '0;
        w_word4 = '0;
        w_lane_word = '0;
        for (int k = 0; k < 8; k++) begin
            w_word8[8*k +: 8] = r_buf[FW'(r_pos + FW'(k))];
            w_lane_word[8*k +: 8] = r_buf[FW'({r_lidx, 3'd0} + k)];
        end
        for (int k = 0; k < 4; k++) begin
            w_word4[8*k +: 8] = r_buf[FW'(r_pos + FW'(k))];
        end
    end

    // sequencer: each product state issues once, then waits for the unit
    always_comb begin
        n_state = r_state;
        n_fill = r_fill;
        n_len = r_len;
        n_lidx = r_lidx;
        n_pos = r_pos;
        n_left = r_left;
        n_h = r_h;
        n_v = r_v;
        n_last = r_last;
        n_ovalid = r_ovalid;
        n_dig = r_dig;
        n_mwait = r_mwait;
        w_req = '{start: 1'b0, a: '0, b: '0};
        w_lane_we = 1'b0;
        w_lane_wd = '0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last = i_last;
                    n_lidx = '0;
                    if (i_byte_valid) begin
                        n_len = r_len + 64'd1;
                        n_fill = r_fill + FW'(1);
                        if (r_fill == FW'(STRIPE - 1)) n_state = S_LANE_MUL0;
                        else if (i_last) n_state = S_FIN_START;
                    end else if (i_last) begin
                        n_state = S_FIN_START;
                    end
                end
            end
            S_LANE_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: w_lane_word, b: P2};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_v = r_lane[r_lidx] + w_prod;
                    n_state = S_LANE_MUL1;
                end
            end
            S_LANE_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_v, 6'd31), b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    w_lane_we = 1'b1;
                    w_lane_wd = w_prod;
                    n_state = S_LANE_NEXT;
                end
            end
            S_LANE_NEXT: begin
                n_lidx = r_lidx + 2'd1;
                if (r_lidx == 2'd3) n_state = r_last ? S_FIN_START : S_IDLE;
                else n_state = S_LANE_MUL0;
            end
            S_FIN_START: begin
                n_lidx = '0;
                n_pos = '0;
                n_left = {1'b0, r_fill};
                // short path follows the wrapped length
                if (r_len >= 64'(STRIPE)) begin
                    n_h = rotl64(r_lane[0], 6'd1) + rotl64(r_lane[1], 6'd7)
                        + rotl64(r_lane[2], 6'd12) + rotl64(r_lane[3], 6'd18);
                    n_state = S_MRG_MUL0;
                end else begin
                    n_h = r_seed + P5;
                    n_state = S_ADD_LEN;
                end
            end
            S_MRG_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: r_lane[r_lidx], b: P2};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_v = w_prod;
                    n_state = S_MRG_MUL1;
                end
            end
            S_MRG_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_v, 6'd31), b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = r_h ^ w_prod;
                    n_state = S_MRG_MUL2;
                end
            end
            S_MRG_MUL2: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: r_h, b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod + P4;
                    n_lidx = r_lidx + 2'd1;
                    n_state = (r_lidx == 2'd3) ? S_ADD_LEN : S_MRG_MUL0;
                end
            end
            S_ADD_LEN: begin
                n_h = r_h + r_len;
                if (r_left >= (FW+1)'(8)) n_state = S_T8_MUL0;
                else if (r_left >= (FW+1)'(4)) n_state = S_T4_MUL0;
                else if (r_left != '0) n_state = S_T1_MUL0;
                else n_state = S_AV_MUL0;
            end
            S_T8_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: w_word8, b: P2};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_v = w_prod;
                    n_state = S_T8_MUL1;
                end
            end
            S_T8_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_v, 6'd31), b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = r_h ^ w_prod;
                    n_state = S_T8_MUL2;
                end
            end
            S_T8_MUL2: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_h, 6'd27), b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod + P4;
                    n_pos = r_pos + FW'(8);
                    n_left = r_left - (FW+1)'(8);
                    n_state = S_ADD_LEN;
                    n_h = w_prod + P4 - r_len; // undone by the length add
                end
            end
            S_T4_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: w_word4, b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = r_h ^ w_prod;
                    n_state = S_T4_MUL1;
                end
            end
            S_T4_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_h, 6'd23), b: P2};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod + P3;
                    n_pos = r_pos + FW'(4);
                    n_left = r_left - (FW+1)'(4);
                    n_state = (r_left == (FW+1)'(4)) ? S_AV_MUL0 : S_T1_MUL0;
                end
            end
            S_T1_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: {56'd0, r_buf[r_pos]}, b: P5};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = r_h ^ w_prod;
                    n_state = S_T1_MUL1;
                end
            end
            S_T1_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: rotl64(r_h, 6'd11), b: P1};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod;
                    n_pos = r_pos + FW'(1);
                    n_left = r_left - (FW+1)'(1);
                    n_state = (r_left == (FW+1)'(1)) ? S_AV_MUL0 : S_T1_MUL0;
                end
            end
            S_AV_MUL0: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: r_h ^ (r_h >> 33), b: P2};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod;
                    n_state = S_AV_MUL1;
                end
            end
            S_AV_MUL1: begin
                if (!r_mwait) begin
                    w_req = '{start: 1'b1, a: r_h ^ (r_h >> 29), b: P3};
                    n_mwait = 1'b1;
                end else if (w_mdone) begin
                    n_mwait = 1'b0;
                    n_h = w_prod ^ (w_prod >> 32);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_dig = r_h;
                    n_fill = '0;
                    n_len = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // lane accumulators: reload on reset, seed write and digest, else written by lane steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_lane[0] <= P1 + P2;
            r_lane[1] <= P2;
            r_lane[2] <= '0;
            r_lane[3] <= '0 - P1;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
            r_lane[0] <= i_cfg_wdata + P1 + P2;
            r_lane[1] <= i_cfg_wdata + P2;
            r_lane[2] <= i_cfg_wdata;
            r_lane[3] <= i_cfg_wdata - P1;
        end else if (r_state == S_OUT && n_state == S_IDLE) begin
            r_lane[0] <= r_seed + P1 + P2;
            r_lane[1] <= r_seed + P2;
            r_lane[2] <= r_seed;
            r_lane[3] <= r_seed - P1;
        end else if (w_lane_we) begin
            r_lane[r_lidx] <= w_lane_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_byte_valid) r_buf[r_fill] <= i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_len <= '0;
            r_ovalid <= 1'b0;
            r_mwait <= 1'b0;
            r_last <= 1'b0;
            r_lidx <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_mwait <= n_mwait;
            r_last <= n_last;
            r_lidx <= n_lidx;
            if (i_cfg_we) begin
                r_fill <= '0;
                r_len <= '0;
            end else begin
                r_fill <= n_fill;
                r_len <= n_len;
            end
        end
        r_pos <= n_pos;
        r_left <= n_left;
        r_h <= n_h;
        r_v <= n_v;
        r_dig <= n_dig;
    end

    // the block takes input only between messages' work
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE && !r_mwait))
        else $error("ready outside idle");
    // a product result only arrives while one was requested
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> r_mwait)
        else $error("unexpected product");
    // a new digest is loaded only from the output state
    a_dig_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("digest from wrong state");
endmodule
`default_nettype wire

// ===== dv/xxh64_stream_hasher_test.sv =====
// testbench: random and directed byte streams into the xxh64 hasher with digest checking
`default_nettype none
module xxh64_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xxh_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       last;
    } t_byte_item;

    typedef enum logic [1:0] {
        K_BYTE,
        K_SEED
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        t_byte_item  item;
        logic [63:0] seed;
    } t_job;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_data = '0;
    logic        in_bval = 1'b0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_digest;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;

    // jobs to send, digests still owed
    t_job        job_q[$];
    logic [63:0] digest_q[$];
    int          err_cnt = 0;
    bit          stim_done = 1'b0;
    bit          stall_hold = 1'b0;

    // set at the rising edge when the offered transaction was taken or none was offered
    bit          in_ready_seen = 1'b1;

    // model state
    logic [63:0] m_seed;
    logic [63:0] m_lane[4];
    logic [7:0]  m_stripe[32];
    int unsigned m_fill;
    logic [63:0] m_len;

    always #2 clk = ~clk;

    xxh64_stream_hasher u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_data_byte  (in_data),
        .i_byte_valid (in_bval),
        .i_last       (in_last),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_digest     (out_digest),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata)
    );

    function automatic logic [63:0] rol(input logic [63:0] x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] w);
        acc = acc + w * P2;
        return rol(acc, 31) * P1;
    endfunction

    function automatic logic [63:0] le_word(input int pos, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v |= 64'(m_stripe[pos + i]) << (8 * i);
        return v;
    endfunction

    function automatic void lanes_reload();
        m_lane[0] = m_seed + P1 + P2;
        m_lane[1] = m_seed + P2;
        m_lane[2] = m_seed;
        m_lane[3] = m_seed - P1;
        m_fill = 0;
        m_len = '0;
    endfunction

    function automatic logic [63:0] finish_digest();
        logic [63:0] h;
        int pos;
        int left;
        pos = 0;
        left = m_fill;
        if (m_len < 64'd32) begin
            h = m_seed + P5;
        end else begin
            h = rol(m_lane[0], 1) + rol(m_lane[1], 7) + rol(m_lane[2], 12) + rol(m_lane[3], 18);
            for (int i = 0; i < 4; i++) begin
                h ^= mix_round('0, m_lane[i]);
                h = h * P1 + P4;
            end
        end
        h += m_len;
        while (left >= 8) begin
            h ^= mix_round('0, le_word(pos, 8));
            h = rol(h, 27) * P1 + P4;
            pos += 8;
            left -= 8;
        end
        if (left >= 4) begin
            h ^= le_word(pos, 4) * P1;
            h = rol(h, 23) * P2 + P3;
            pos += 4;
            left -= 4;
        end
        while (left > 0) begin
            h ^= 64'(m_stripe[pos]) * P5;
            h = rol(h, 11) * P1;
            pos++;
            left--;
        end
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;
        return h;
    endfunction

    // advance the model by one accepted transaction
    function automatic void hash_accept(input t_byte_item it);
        if (it.bval) begin
            m_stripe[m_fill] = it.data;
            m_fill++;
            m_len++;
            if (m_fill == 32) begin
                for (int i = 0; i < 4; i++) m_lane[i] = mix_round(m_lane[i], le_word(8 * i, 8));
                m_fill = 0;
            end
        end
        if (it.last) begin
            digest_q.push_back(finish_digest());
            lanes_reload();
        end
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic bv, input logic lst);
        t_job j;
        j.kind = K_BYTE;
        j.item = '{data: d, bval: bv, last: lst};
        j.seed = '0;
        job_q.push_back(j);
    endfunction

    function automatic void push_seed(input logic [63:0] s);
        t_job j;
        j.kind = K_SEED;
        j.item = '0;
        j.seed = s;
        job_q.push_back(j);
    endfunction

    // message of n bytes with random content, optional idle items sprinkled in
    function automatic void push_message(input int n, input bit noise);
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 9) == 0) push_byte(8'($urandom), 1'b0, 1'b0);
            push_byte(8'($urandom), 1'b1, (i == n - 1));
        end
        if (n == 0) push_byte(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus plan
    initial begin
        int n;
        int total;
        // directed: empty, byte extremes, idle item, finish without byte, tail sizes
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hff, 1'b1, 1'b1);
        push_byte(8'h5a, 1'b0, 1'b0);
        push_byte(8'ha5, 1'b1, 1'b0);
        push_byte(8'h3c, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_message(4, 1'b0);
        push_message(8, 1'b0);
        push_seed(64'hffff_ffff_ffff_ffff);
        push_message(3, 1'b0);
        push_message(32, 1'b0);
        push_seed('0);
        push_message(31, 1'b0);
        // partial message abandoned by a seed write
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'h22, 1'b1, 1'b0);
        push_seed(64'h0123_4567_89ab_cdef);
        push_message(45, 1'b0);
        // random part, mostly short messages and a few long ones
        total = 0;
        while (total < 600) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(32, 100);
                1: n = 0;
                default: n = $urandom_range(1, 31);
            endcase
            push_message(n, 1'b1);
            total += n + 1;
            if ($urandom_range(0, 19) == 0) push_seed({$urandom, $urandom});
        end
        push_seed('0);
        push_message(40, 1'b0);
    end

    // driver: one job at a time, seed writes only when nothing is in flight
    always @(negedge clk) begin
        static int gap = 0;
        static int settle = 0;
        t_job j;
        if (rst_n && !(in_valid && !in_ready_seen)) begin
            cfg_we <= 1'b0;
            if (gap > 0) begin
                gap--;
                in_valid <= 1'b0;
            end else if (job_q.size() == 0) begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (job_q[0].kind == K_SEED) begin
                in_valid <= 1'b0;
                if (digest_q.size() != 0) begin
                    settle = 0;
                end else if (settle < 300) begin
                    settle++;
                end else begin
                    j = job_q.pop_front();
                    cfg_we <= 1'b1;
                    cfg_wdata <= j.seed;
                    m_seed = j.seed;
                    lanes_reload();
                    settle = 0;
                end
            end else begin
                j = job_q.pop_front();
                in_valid <= 1'b1;
                in_data <= j.item.data;
                in_bval <= j.item.bval;
                in_last <= j.item.last;
                gap = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            hash_accept('{data: in_data, bval: in_bval, last: in_last});
            in_ready_seen <= 1'b1;
        end else if (in_valid) begin
            in_ready_seen <= 1'b0;
        end else begin
            in_ready_seen <= 1'b1;
        end
    end

    // receiver back-pressure, with one long hold-off early in the run
    always @(negedge clk) begin
        static int hold = 0;
        static bit long_done = 1'b0;
        if (!long_done && digest_q.size() >= 1) begin
            long_done = 1'b1;
            hold = 400;
        end
        if (hold > 0) begin
            hold--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            hold = pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: compare each digest transaction with the oldest expected digest
    always @(posedge clk) begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest, expected none, actual %h", $realtime, out_digest);
                err_cnt++;
            end else begin
                want = digest_q.pop_front();
                if (out_digest !== want) begin
                    $display("%0t: digest mismatch, expected %h, actual %h",
                             $realtime, want, out_digest);
                    err_cnt++;
                end
            end
        end
    end

    // reset, then wait for the queues to drain
    initial begin
        m_seed = '0;
        for (int i = 0; i < 32; i++) m_stripe[i] = '0;
        lanes_reload();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && in_ready_seen && !in_valid && digest_q.size() == 0);
        repeat (400) @(posedge clk);
        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("xxh64_stream_hasher_test: done, clean");
        end else begin
            $display("xxh64_stream_hasher_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("xxh64_stream_hasher_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/xxh_pkg.sv
src/xxh_mul.sv
src/xxh64_stream_hasher.sv
dv/xxh64_stream_hasher_test.sv
